>>> src/chm_pkg.sv
// chained hash map package: request/result payload types, request codes, fsm states
// no dependencies
package chm_pkg;

  typedef enum logic [1:0] {
    REQ_GET    = 2'd0,
    REQ_SET    = 2'd1,
    REQ_GETINS = 2'd2,
    REQ_RSVD   = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [31:0] new_value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        inserted;
    logic        pool_full;
    logic [8:0]  entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HEAD,
    ST_RD,
    ST_CMP,
    ST_FREE,
    ST_LINK,
    ST_DONE
  } state_e;

endpackage

>>> src/chained_hash_map_lookup_insert_core.sv
// chained hash map top level: sequencer, bucket table, entry memories
// depends on chm_pkg
//
// usage: pulse start_i with req_i while busy_o is low; the transaction is
// taken at that edge and busy_o rises. The sequencer reads the bucket head,
// then walks the chain one entry at a time (memory read, then key compare)
// through one shared key comparator. On a miss that inserts, it then reads
// the free-list link and links the new slot at the chain head.
// One transaction at a time: the next one can be taken while done_o is high.
// result: rsp_o is valid for exactly one cycle while done_o is high; the
// receiver cannot stall, so the result is dropped after that cycle.
// reset: the bucket table clears at once; the free-list links are then
// rebuilt by a pass over all CAPACITY slots during which busy_o stays high.
// key and value stores are undefined until written.
// entry_count is 9 bits wide and wraps for CAPACITY above 511.
module chained_hash_map_lookup_insert_core #(
  parameter int BUCKETS  = 16,
  parameter int CAPACITY = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  chm_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output chm_pkg::rsp_t rsp_o
);
  import chm_pkg::*;

  localparam int SW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [SW-1:0] NullSlot = SW'(CAPACITY);
  localparam logic [SW-1:0] LastSlot = SW'(CAPACITY - 1);

  // memories
  logic [31:0]   key_mem  [CAPACITY];
  logic [31:0]   val_mem  [CAPACITY];
  logic [SW-1:0] link_mem [CAPACITY];
  logic [SW-1:0] head_q   [BUCKETS];

  state_e state_q, state_d;
  req_t   req_q;
  logic [BW-1:0] bkt_q;
  logic [SW-1:0] slot_q, slot_d, free_q, steps_q;
  logic [SW-1:0] cnt_q;
  logic [31:0]   rkey_q, rval_q;
  logic [SW-1:0] rlink_q, flink_q;
  rsp_t          rsp_q;
  logic          done_q;

  logic [BW-1:0] bkt_w;
  logic          is_ins, key_eq, walk_end;

  // bucket select: (key >> 4) mod BUCKETS
  assign bkt_w    = BW'((req_i.key >> 4) % BUCKETS);
  assign is_ins   = (req_q.req_type == REQ_SET) || (req_q.req_type == REQ_GETINS);
  assign key_eq   = (rkey_q == req_q.key);
  assign walk_end = (slot_q == NullSlot) || (steps_q == NullSlot);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: if (slot_q == LastSlot) state_d = ST_IDLE;
      ST_IDLE: if (start_i) state_d = ST_HEAD;
      ST_HEAD: state_d = ST_RD;
      ST_RD: begin
        if (walk_end) state_d = (is_ins && free_q != NullSlot) ? ST_FREE : ST_DONE;
        else state_d = ST_CMP;
      end
      ST_CMP:  state_d = key_eq ? ST_DONE : ST_RD;
      ST_FREE: state_d = ST_LINK;
      ST_LINK: state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // slot pointer
  always_comb begin
    slot_d = slot_q;
    unique case (state_q)
      ST_INIT: slot_d = slot_q + 1'b1;
      ST_HEAD: slot_d = head_q[bkt_q];
      ST_CMP:  if (!key_eq) slot_d = rlink_q;
      default: slot_d = slot_q;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      slot_q  <= '0;
      free_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      steps_q <= '0;
      for (int i = 0; i < BUCKETS; i++) head_q[i] <= NullSlot;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      done_q  <= (state_q == ST_DONE);
      if (state_q == ST_HEAD) steps_q <= '0;
      if (state_q == ST_CMP) steps_q <= steps_q + 1'b1;
      if (state_q == ST_LINK) begin
        free_q         <= flink_q;
        head_q[bkt_q]  <= free_q;
        cnt_q          <= cnt_q + 1'b1;
      end
    end
  end

  // request capture and result build
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      req_q <= req_i;
      bkt_q <= bkt_w;
    end
    unique case (state_q)
      ST_HEAD: begin
        rsp_q <= '0;
      end
      ST_RD: begin
        if (walk_end && is_ins && free_q == NullSlot) rsp_q.pool_full <= 1'b1;
      end
      ST_CMP: begin
        if (key_eq) begin
          rsp_q.hit        <= 1'b1;
          rsp_q.read_value <= (req_q.req_type == REQ_SET) ? req_q.new_value : rval_q;
        end
      end
      ST_LINK: begin
        rsp_q.inserted   <= 1'b1;
        rsp_q.read_value <= (req_q.req_type == REQ_SET) ? req_q.new_value : '0;
      end
      ST_DONE: begin
        rsp_q.entry_count <= 9'(cnt_q);
      end
      default: ;
    endcase
  end

  // entry memories: one read port, one write port, registered reads
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD && !walk_end) begin
      rkey_q  <= key_mem[slot_q[AW-1:0]];
      rval_q  <= val_mem[slot_q[AW-1:0]];
      rlink_q <= link_mem[slot_q[AW-1:0]];
    end
    if (state_q == ST_FREE) flink_q <= link_mem[free_q[AW-1:0]];
    if (state_q == ST_INIT) link_mem[slot_q[AW-1:0]] <= slot_q + 1'b1;
    if (state_q == ST_CMP && key_eq && req_q.req_type == REQ_SET)
      val_mem[slot_q[AW-1:0]] <= req_q.new_value;
    if (state_q == ST_LINK) begin
      key_mem[free_q[AW-1:0]]  <= req_q.key;
      val_mem[free_q[AW-1:0]]  <= (req_q.req_type == REQ_SET) ? req_q.new_value : '0;
      link_mem[free_q[AW-1:0]] <= head_q[bkt_q];
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_ins_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.inserted && (rsp_o.hit || rsp_o.pool_full)))
    else $error("result flags clash");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SW'(CAPACITY)) else $error("count overflow");
  a_full_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.pool_full |-> free_q == NullSlot) else $error("false full");
`endif

endmodule
